@@ rtl/nslt_pkg.sv @@
// Shared constants, codes, command/status types and helpers for the NMEA sentence table.
package nslt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int LINE_BYTES_DEF    = 128;
  localparam int KEY_BYTES_DEF     = 6;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam int          MIN_LINE    = 9;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [2:0] ST_REPLACED = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_BAD_HEX  = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;
  localparam logic [2:0] ST_TIMEOUT  = 3'd6;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic copy_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ev_read;
    logic ev_timeout;
    logic ev_end;
    logic line_ok;
    logic walk_last;
    logic copy_last;
    logic out_free;
  } sts_t;

  // {valid, value} of one ASCII hex digit, either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

endpackage

@@ rtl/nslt_ctrl.sv @@
// Sequencing state machine: accept, table walk, copy, commit, result hand-off.
module nslt_ctrl import nslt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_COPY, S_COMMIT, S_RESULT} state_t;
  state_t state;

  assign in_ready      = (state == S_IDLE);
  assign cmd.accept    = in_valid && (state == S_IDLE);
  assign cmd.walk_step = (state == S_WALK);
  assign cmd.copy_step = (state == S_COPY);
  assign cmd.commit    = (state == S_COMMIT);
  assign cmd.load_out  = (state == S_RESULT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (sts.ev_read || sts.ev_timeout) state <= S_RESULT;
            else if (sts.ev_end) state <= sts.line_ok ? S_WALK : S_RESULT;
          end
        end
        S_WALK:   if (sts.walk_last) state <= S_COPY;
        S_COPY:   if (sts.copy_last) state <= S_COMMIT;
        S_COMMIT: state <= S_RESULT;
        S_RESULT: if (sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/nslt_dp.sv @@
// Datapath: framing, checksum, line buffer, entry table, text memory, output register.
module nslt_dp import nslt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int LINE_BYTES    = LINE_BYTES_DEF,
  parameter int KEY_BYTES     = KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [4:0]  query_slot,
  input  logic [6:0]  query_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [2:0]  line_status,
  output logic [4:0]  slot_used,
  output logic [6:0]  line_length,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic [31:0] entry_age_ms
);

  localparam int SW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(LINE_BYTES);
  localparam int AW = $clog2(TABLE_ENTRIES * LINE_BYTES);
  localparam int KW = 8 * KEY_BYTES;

  logic [15:0]   timeout;
  logic [31:0]   now_ms, start_stamp;
  logic          in_sentence;
  logic [LW-1:0] line_fill, rep_len;
  logic [7:0]    xsum, tail0, tail1, tail2;
  logic [KW-1:0] line_key;
  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    text_mem [TABLE_ENTRIES * LINE_BYTES];

  logic [TABLE_ENTRIES-1:0] occupied;
  logic [KW-1:0] ekey   [TABLE_ENTRIES];
  logic [31:0]   estamp [TABLE_ENTRIES];
  logic [LW-1:0] elen   [TABLE_ENTRIES];

  logic          res_kind;
  logic [2:0]    lstat;
  logic [SW-1:0] pos;
  logic [4:0]    q_slot;
  logic [6:0]    q_off;
  logic [7:0]    text_q;

  logic [SW-1:0] widx, epos, oldest;
  logic          found_empty;
  logic [31:0]   oldest_age;

  logic [LW-1:0] cidx, wr_idx;
  logic          wr_pend;
  logic [7:0]    line_q;

  // incoming byte decode
  logic          byte_in, starting, active, tmo, eol, store;
  logic [31:0]   start_eff;
  logic [LW-1:0] fill_eff;
  logic [4:0]    hex_hi, hex_lo;
  logic          short_line, hex_bad, sum_bad;

  assign byte_in   = (mode == MODE_BYTE) && !rx_byte[7];
  assign starting  = byte_in && !in_sentence && (rx_byte == CH_DOLLAR);
  assign active    = byte_in && (in_sentence || starting);
  assign start_eff = starting ? now_ms : start_stamp;
  assign fill_eff  = starting ? '0 : line_fill;
  assign tmo       = active && ((now_ms - start_eff) > {16'd0, timeout});
  assign eol       = active && !tmo && (rx_byte == CH_CR || rx_byte == CH_LF);
  assign store     = active && !tmo && !eol && (fill_eff < LW'(LINE_BYTES - 1));

  // checksum covers bytes 1..len-4; xsum runs over 1..len-1, so strip the tail
  assign hex_hi     = hex_digit(tail1);
  assign hex_lo     = hex_digit(tail0);
  assign short_line = 32'(line_fill) < MIN_LINE;
  assign hex_bad    = !hex_hi[4] || !hex_lo[4];
  assign sum_bad    = {hex_hi[3:0], hex_lo[3:0]} != (xsum ^ tail0 ^ tail1 ^ tail2);

  // table entry port: walk index during the walk, else the query slot
  logic [SW-1:0] tidx;
  logic          t_occ;
  logic [KW-1:0] t_key;
  logic [31:0]   t_age;
  logic [LW-1:0] t_len;

  assign tidx  = cmd.walk_step ? widx : SW'(q_slot);
  assign t_occ = occupied[tidx];
  assign t_key = ekey[tidx];
  assign t_age = now_ms - estamp[tidx];
  assign t_len = elen[tidx];

  logic          hit, fe_n, older, walk_last;
  logic [SW-1:0] epos_n, old_n;
  logic [31:0]   oa_n;

  assign hit       = t_occ && (t_key == line_key);
  assign fe_n      = found_empty || !t_occ;
  assign epos_n    = (!found_empty && !t_occ) ? widx : epos;
  assign older     = t_occ && (widx == '0 || t_age > oldest_age);
  assign old_n     = older ? widx : oldest;
  assign oa_n      = older ? t_age : oldest_age;
  assign walk_last = hit || (widx == SW'(TABLE_ENTRIES - 1));

  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = AW'(pos) * AW'(LINE_BYTES) + AW'(wr_idx);
  assign rd_addr = AW'(SW'(query_slot)) * AW'(LINE_BYTES) + AW'(query_offset);

  // read answer
  logic q_in, rv;
  assign q_in = 32'(q_slot) < TABLE_ENTRIES;
  assign rv   = q_in && t_occ;

  assign sts.ev_read    = (mode == MODE_READ);
  assign sts.ev_timeout = tmo;
  assign sts.ev_end     = eol;
  assign sts.line_ok    = !short_line && !hex_bad && !sum_bad;
  assign sts.walk_last  = walk_last;
  assign sts.copy_last  = (cidx == line_fill - LW'(1));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout     <= TIMEOUT_RST;
      now_ms      <= '0;
      start_stamp <= '0;
      in_sentence <= 1'b0;
      line_fill   <= '0;
      rep_len     <= '0;
      occupied    <= '0;
      res_kind    <= 1'b0;
      lstat       <= ST_REPLACED;
      pos         <= '0;
      widx        <= '0;
      epos        <= '0;
      oldest      <= '0;
      oldest_age  <= '0;
      found_empty <= 1'b0;
      cidx        <= '0;
      wr_pend     <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        estamp[i] <= '0;
        elen[i]   <= '0;
      end
    end else begin
      if (cfg_valid) timeout <= cfg_data;

      if (cmd.accept) begin
        unique case (mode)
          MODE_TICK: now_ms <= now_ms + 32'd1;
          MODE_READ: begin
            res_kind <= 1'b1;
            q_slot   <= query_slot;
            q_off    <= query_offset;
          end
          MODE_BYTE: begin
            res_kind <= 1'b0;
            if (starting) begin
              in_sentence <= 1'b1;
              start_stamp <= now_ms;
              line_fill   <= '0;
            end
            if (tmo) begin
              in_sentence <= 1'b0;
              line_fill   <= '0;
              rep_len     <= fill_eff;
              lstat       <= ST_TIMEOUT;
            end else if (eol) begin
              in_sentence <= 1'b0;
              rep_len     <= line_fill;
              if (short_line) lstat <= ST_SHORT;
              else if (hex_bad) lstat <= ST_BAD_HEX;
              else if (sum_bad) lstat <= ST_MISMATCH;
              widx        <= '0;
              found_empty <= 1'b0;
              oldest      <= '0;
              oldest_age  <= '0;
            end else if (store) begin
              line_fill <= fill_eff + LW'(1);
            end
          end
          default: ;
        endcase
      end

      if (cmd.walk_step) begin
        found_empty <= fe_n;
        epos        <= epos_n;
        oldest      <= old_n;
        oldest_age  <= oa_n;
        widx        <= widx + SW'(1);
        if (walk_last) begin
          pos   <= hit ? widx : (fe_n ? epos_n : old_n);
          lstat <= hit ? ST_REPLACED : (fe_n ? ST_EMPTY : ST_EVICTED);
          cidx  <= '0;
        end
      end

      wr_pend <= cmd.copy_step;
      if (cmd.copy_step) cidx <= cidx + LW'(1);

      if (cmd.commit) begin
        occupied[pos] <= 1'b1;
        estamp[pos]   <= start_stamp;
        elen[pos]     <= line_fill;
      end

      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && store) begin
      line_mem[fill_eff] <= rx_byte;
      xsum  <= (fill_eff == '0) ? 8'd0 : (xsum ^ rx_byte);
      tail2 <= tail1;
      tail1 <= tail0;
      tail0 <= rx_byte;
      for (int k = 0; k < KEY_BYTES; k++) begin
        if (fill_eff == LW'(k)) line_key[k*8 +: 8] <= rx_byte;
      end
    end
    if (cmd.copy_step) begin
      line_q <= line_mem[cidx];
      wr_idx <= cidx;
    end
    if (cmd.commit) ekey[pos] <= line_key;
    if (cmd.load_out) begin
      result_kind <= res_kind;
      if (res_kind) begin
        line_status  <= ST_REPLACED;
        slot_used    <= '0;
        line_length  <= '0;
        read_valid   <= rv;
        read_byte    <= (rv && (32'(q_off) < 32'(t_len))) ? text_q : 8'd0;
        entry_age_ms <= rv ? t_age : 32'd0;
      end else begin
        line_status  <= lstat;
        slot_used    <= (lstat == ST_REPLACED || lstat == ST_EMPTY || lstat == ST_EVICTED)
                        ? 5'(pos) : 5'd0;
        line_length  <= 7'(rep_len);
        read_valid   <= 1'b0;
        read_byte    <= 8'd0;
        entry_age_ms <= 32'd0;
      end
    end
  end

  // stored text memory: one write port (copy), one registered read port (query)
  always_ff @(posedge clk) begin
    if (wr_pend) text_mem[wr_addr] <= line_q;
    if (cmd.accept && mode == MODE_READ) text_q <= text_mem[rd_addr];
  end

endmodule

@@ rtl/nmea_sentence_latest_table_top.sv @@
// Top level of the NMEA sentence framer with latest-sentence table.
// Tick and unused-mode items, and bytes that neither end nor time out a line, keep the block idle.
// A read, timeout or rejected line enters the result state, which loads its result once the output
// register is free, then returns to idle. A good line end walks the table (at most TABLE_ENTRIES
// entries, fewer on a key hit), copies the line one byte a cycle, commits it and loads the result.
// Reset (rst, synchronous): table empty via occupied flags, clock 0, timeout 500; no clear pass.
module nmea_sentence_latest_table_top import nslt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int LINE_BYTES    = LINE_BYTES_DEF,
  parameter int KEY_BYTES     = KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: sentence timeout in ms
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [4:0]  query_slot,
  input  logic [6:0]  query_offset,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [2:0]  line_status,
  output logic [4:0]  slot_used,
  output logic [6:0]  line_length,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic [31:0] entry_age_ms
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller: sequences accept, walk, copy, commit and result hand-off
  nslt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: framing, checks, table and text memory
  nslt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LINE_BYTES    (LINE_BYTES),
    .KEY_BYTES     (KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .query_slot   (query_slot),
    .query_offset (query_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .line_status  (line_status),
    .slot_used    (slot_used),
    .line_length  (line_length),
    .read_byte    (read_byte),
    .read_valid   (read_valid),
    .entry_age_ms (entry_age_ms)
  );

  // a tick transaction never leaves the idle state
  a_tick_stays_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_TICK |=> in_ready)
    else $error("tick transaction stalled input");

  // a read transaction always produces a result, so input closes next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_READ |=> !in_ready)
    else $error("read transaction did not enter result stage");

  // results are loaded only from the result stage
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy stage");

endmodule

@@ dv/tb_nmea_sentence_latest_table_top.sv @@
// Self-checking testbench for the NMEA sentence framer and latest-sentence table.
`timescale 1ns / 1ps

module tb_nmea_sentence_latest_table_top;
  import nslt_pkg::*;

  typedef struct {
    bit        kind;
    bit [2:0]  status;
    bit [4:0]  slot;
    bit [6:0]  len;
    bit [7:0]  rbyte;
    bit        rvalid;
    bit [31:0] age;
  } outcome_t;

  // Scoreboard: keeps its own copy of the framer and table state and
  // queues the outcome each accepted transaction should produce.
  class nmea_table_scoreboard;
    bit [15:0] timeout_ms;
    bit [31:0] clock_ms;
    bit        framing;
    bit [31:0] line_start;
    bit [7:0]  line_buf[128];
    int        line_cnt;
    bit        occupied[32];
    bit [47:0] key[32];
    bit [31:0] stamp[32];
    bit [7:0]  text[32][128];
    int        length[32];
    outcome_t  pending[$];
    int        errors;
    int        stored_lines;
    int        rejected_lines;
    int        reads;

    function new();
      timeout_ms = TIMEOUT_RST;
      clock_ms   = 0;
      framing    = 0;
      line_start = 0;
      line_cnt   = 0;
      errors     = 0;
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function int hex_val(bit [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    function void push_line(bit [2:0] st, bit [4:0] sl, int len);
      outcome_t o;
      o = '{kind: 1'b0, status: st, slot: sl, len: len[6:0], rbyte: 8'd0,
            rvalid: 1'b0, age: 32'd0};
      pending.push_back(o);
      if (st <= ST_EVICTED) stored_lines++;
      else rejected_lines++;
    endfunction

    // line end: checks, then table placement
    function void close_line();
      bit [7:0]  sum;
      int        hi, lo, pos, oldest;
      bit        got_empty, got_match;
      bit [47:0] k;
      bit [31:0] oldest_age, age;
      sum = 0;
      got_empty = 0;
      got_match = 0;
      pos = 0;
      oldest = 0;
      oldest_age = 0;
      framing = 0;
      if (line_cnt < MIN_LINE) begin
        push_line(ST_SHORT, 0, line_cnt);
        return;
      end
      for (int i = 1; i + 3 < line_cnt; i++) sum ^= line_buf[i];
      hi = hex_val(line_buf[line_cnt-2]);
      lo = hex_val(line_buf[line_cnt-1]);
      if (hi < 0 || lo < 0) begin
        push_line(ST_BAD_HEX, 0, line_cnt);
        return;
      end
      if (hi * 16 + lo != sum) begin
        push_line(ST_MISMATCH, 0, line_cnt);
        return;
      end
      for (int i = 0; i < 6; i++) k[8*i +: 8] = line_buf[i];
      for (int i = 0; i < 32; i++) begin
        if (!occupied[i]) begin
          if (!got_empty) begin
            got_empty = 1;
            pos = i;
          end
          continue;
        end
        if (key[i] == k) begin
          got_match = 1;
          pos = i;
          break;
        end
        age = clock_ms - stamp[i];
        if (i == 0 || age > oldest_age) begin
          oldest_age = age;
          oldest = i;
        end
      end
      if (!got_match && !got_empty) pos = oldest;
      occupied[pos] = 1;
      key[pos] = k;
      stamp[pos] = line_start;
      length[pos] = line_cnt;
      for (int i = 0; i < line_cnt; i++) text[pos][i] = line_buf[i];
      push_line(got_match ? ST_REPLACED : (got_empty ? ST_EMPTY : ST_EVICTED), pos, line_cnt);
    endfunction

    function void note_item(bit [1:0] md, bit [7:0] b, bit [4:0] qs, bit [6:0] qo);
      outcome_t o;
      if (md == MODE_TICK) begin
        clock_ms++;
        return;
      end
      if (md == MODE_READ) begin
        o = '{kind: 1'b1, status: 3'd0, slot: 5'd0, len: 7'd0, rbyte: 8'd0,
              rvalid: 1'b0, age: 32'd0};
        if (occupied[qs]) begin
          o.rvalid = 1;
          o.age = clock_ms - stamp[qs];
          if (qo < length[qs]) o.rbyte = text[qs][qo];
        end
        pending.push_back(o);
        reads++;
        return;
      end
      if (md != MODE_BYTE || b > 127) return;
      if (!framing && b == CH_DOLLAR) begin
        line_cnt = 0;
        line_start = clock_ms;
        framing = 1;
      end
      if (!framing) return;
      if (clock_ms - line_start > {16'd0, timeout_ms}) begin
        push_line(ST_TIMEOUT, 0, line_cnt);
        line_cnt = 0;
        framing = 0;
        return;
      end
      if (b == CH_CR || b == CH_LF) begin
        close_line();
        return;
      end
      if (line_cnt < 127) line_buf[line_cnt++] = b;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(outcome_t got);
      outcome_t w;
      if (pending.size() == 0) begin
        report("result with no outstanding expectation");
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) report($sformatf("kind %0d want %0d", got.kind, w.kind));
      if (got.status != w.status)
        report($sformatf("status %0d want %0d", got.status, w.status));
      if (got.slot != w.slot) report($sformatf("slot %0d want %0d", got.slot, w.slot));
      if (got.len != w.len) report($sformatf("length %0d want %0d", got.len, w.len));
      if (got.rbyte != w.rbyte)
        report($sformatf("read byte %h want %h", got.rbyte, w.rbyte));
      if (got.rvalid != w.rvalid)
        report($sformatf("read valid %0d want %0d", got.rvalid, w.rvalid));
      if (got.age != w.age) report($sformatf("age %0d want %0d", got.age, w.age));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [4:0]  query_slot;
  logic [6:0]  query_offset;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [2:0]  line_status;
  logic [4:0]  slot_used;
  logic [6:0]  line_length;
  logic [7:0]  read_byte;
  logic        read_valid;
  logic [31:0] entry_age_ms;

  nmea_sentence_latest_table_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .query_slot   (query_slot),
    .query_offset (query_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .line_status  (line_status),
    .slot_used    (slot_used),
    .line_length  (line_length),
    .read_byte    (read_byte),
    .read_valid   (read_valid),
    .entry_age_ms (entry_age_ms)
  );

  nmea_table_scoreboard sb = new();

  int items_sent;
  int burst_left;
  int hold_req;    // bumped by stimulus to ask for a long receiver hold-off
  int hold_served;
  int hold_left;
  int cycle_cnt;

  initial clk = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stall pattern, with quiet windows of no stalls, plus
  // a long hold-off on request so the block backs up into its input.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_served) begin
      hold_served <= hold_req;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if ((cycle_cnt / 300) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result monitor: values sampled at the edge, before this edge's updates
  always @(posedge clk) begin
    outcome_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{kind: result_kind, status: line_status, slot: slot_used, len: line_length,
              rbyte: read_byte, rvalid: read_valid, age: entry_age_ms};
      sb.check_result(got);
    end
  end

  // One input transaction; sender idles between bursts of random length.
  task send_item(bit [1:0] md, bit [7:0] b, bit [4:0] qs, bit [6:0] qo);
    in_valid <= 1'b1;
    mode <= md;
    rx_byte <= b;
    query_slot <= qs;
    query_offset <= qo;
    do @(posedge clk); while (!in_ready);
    sb.note_item(md, b, qs, qo);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(0, 12);
    end
  endtask

  task send_byte(bit [7:0] b);
    send_item(MODE_BYTE, b, $urandom, $urandom);
  endtask

  task send_tick();
    send_item(MODE_TICK, $urandom, $urandom, $urandom);
  endtask

  task send_read(bit [4:0] qs, bit [6:0] qo);
    send_item(MODE_READ, $urandom, qs, qo);
  endtask

  function bit [7:0] hex_char(bit [3:0] n, bit lower);
    if (n < 10) return "0" + n;
    return (lower ? "a" : "A") + n - 10;
  endfunction

  // Sentence flaws
  localparam int FL_NONE    = 0;
  localparam int FL_WRONG   = 1;
  localparam int FL_NOT_HEX = 2;
  localparam int FL_SHORT   = 3;
  localparam int FL_LOWER   = 4;
  localparam int FL_STALE   = 5;

  // '$' + 5-char key + ',' + body + '*' + checksum + CR or LF
  task send_sentence(int flaw, int body_len, int key_id);
    bit [7:0] s[$];
    bit [7:0] sum;
    bit       lower;
    int       cut;
    lower = (flaw == FL_LOWER);
    s.push_back(CH_DOLLAR);
    s.push_back("G");
    s.push_back("P");
    s.push_back("A" + key_id % 26);
    s.push_back("A" + (key_id / 26) % 26);
    s.push_back("A" + (key_id / 676) % 26);
    s.push_back(",");
    repeat (body_len) s.push_back($urandom_range(8'h20, 8'h7E));
    sum = 0;
    for (int i = 1; i < s.size(); i++) sum ^= s[i];
    s.push_back("*");
    s.push_back(hex_char(sum[7:4], lower));
    s.push_back(hex_char(flaw == FL_WRONG ? sum[3:0] + 4'd1 : sum[3:0], lower));
    if (flaw == FL_NOT_HEX) s[s.size()-1 - $urandom_range(0, 1)] = "G" + $urandom_range(0, 8);
    if (flaw == FL_SHORT) s = s[0:$urandom_range(0, 7)];
    cut = $urandom_range(1, s.size() - 1);
    foreach (s[i]) begin
      if (flaw == FL_STALE && i == cut) repeat (sb.timeout_ms + 1) send_tick();
      else if ($urandom_range(0, 60) == 0) send_tick();
      send_byte(s[i]);
    end
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // Block must be idle: all results in, then room for a table walk and copy.
  task write_timeout(bit [15:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.timeout_ms = v;
  endtask

  task random_traffic(int n);
    int pick, flaw;
    while (items_sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        flaw = $urandom_range(0, 9);
        if (flaw > FL_STALE || (flaw == FL_STALE && sb.timeout_ms > 12)) flaw = FL_NONE;
        send_sentence(flaw, ($urandom_range(0, 30) == 0) ? $urandom_range(60, 135)
                                                         : $urandom_range(0, 16),
                      $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(0, 599));
      end else if (pick < 75) begin
        send_read($urandom, ($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) send_tick();
      end else if (pick < 95) begin
        send_byte($urandom);
      end else begin
        send_item(2'd3, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    in_valid = 0;
    mode = MODE_BYTE;
    rx_byte = 0;
    query_slot = 0;
    query_offset = 0;
    out_ready = 0;
    items_sent = 0;
    burst_left = 0;
    hold_req = 0;
    hold_served = 0;
    hold_left = 0;
    cycle_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty reads, ignored bytes, empty-slot store, key replace, short, bad-hex and mismatched lines
    send_read(0, 0);
    send_read(31, 127);
    send_byte("A");
    send_byte(8'hFF);
    send_item(2'd3, 8'h24, 5'd31, 7'd127);
    send_sentence(FL_NONE, 4, 1);
    send_sentence(FL_NONE, 2, 1);
    send_sentence(FL_SHORT, 0, 2);
    send_sentence(FL_NOT_HEX, 3, 2);
    send_sentence(FL_WRONG, 3, 2);
    send_sentence(FL_LOWER, 3, 3);
    send_byte(CH_DOLLAR);
    send_byte(CH_DOLLAR);
    send_byte(CH_LF);
    send_tick();
    send_read(0, 0);
    send_read(0, 126);
    send_read(1, 5);

    // timeout 0: any tick inside a sentence aborts it
    write_timeout(16'd0);
    send_sentence(FL_STALE, 3, 4);
    random_traffic(400);

    // fill past 32 entries to force eviction, under the widest window
    write_timeout(16'hFFFF);
    for (int k = 100; k < 140; k++) send_sentence(FL_NONE, 0, k);
    random_traffic(700);

    // back-pressure: long receiver hold-off while bytes keep coming
    write_timeout(16'd7);
    hold_req <= hold_req + 1;
    random_traffic(1100);

    write_timeout(TIMEOUT_RST);
    random_traffic(1450);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: %0d lines stored, %0d lines rejected, %0d reads",
             items_sent, sb.stored_lines, sb.rejected_lines, sb.reads);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/nslt_pkg.sv
rtl/nslt_ctrl.sv
rtl/nslt_dp.sv
rtl/nmea_sentence_latest_table_top.sv
dv/tb_nmea_sentence_latest_table_top.sv
